// ===== rtl/tlwf_pkg.sv =====
package tlwf_pkg;

	localparam int unsigned WordW  = 64;
	localparam int unsigned HalfW  = 32;
	localparam int unsigned IndexW = 32;
	localparam int unsigned StepW  = 3;
	localparam int unsigned PhaseW = 3;

	localparam logic [WordW-1:0] SeedLow  = 64'h243f6a8885a308d3;
	localparam logic [WordW-1:0] SeedHigh = 64'h13198a2e03707344;
	localparam logic [WordW-1:0] Golden   = 64'h9e3779b97f4a7c15;
	localparam logic [WordW-1:0] SmMulA   = 64'hbf58476d1ce4e5b9;
	localparam logic [WordW-1:0] SmMulB   = 64'h94d049bb133111eb;
	localparam logic [WordW-1:0] LowMul   = 64'h9e3779b185ebca87;
	localparam logic [WordW-1:0] HiXor    = 64'hd6e8feb86659fd93;
	localparam logic [WordW-1:0] HiMulB   = 64'ha5a3564e27f8862f;
	localparam logic [WordW-1:0] LowFill  = 64'h6a09e667f3bcc909;
	localparam logic [WordW-1:0] HighFill = 64'hbb67ae8584caa73b;

	// multiplication steps of one word, in order
	localparam logic [StepW-1:0] StepGolden = 3'd0;
	localparam logic [StepW-1:0] StepSmA    = 3'd1;
	localparam logic [StepW-1:0] StepSmB    = 3'd2;
	localparam logic [StepW-1:0] StepLow    = 3'd3;
	localparam logic [StepW-1:0] StepHiA    = 3'd4;
	localparam logic [StepW-1:0] StepHiB    = 3'd5;
	localparam logic [StepW-1:0] StepHigh   = 3'd6;

	// phases of one 64-bit multiplication on the 32x32 unit
	localparam logic [PhaseW-1:0] PhLoLo  = 3'd0;
	localparam logic [PhaseW-1:0] PhHiLo  = 3'd1;
	localparam logic [PhaseW-1:0] PhLoHi  = 3'd2;
	localparam logic [PhaseW-1:0] PhSum   = 3'd3;
	localparam logic [PhaseW-1:0] PhPost  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	function automatic logic [WordW-1:0] step_const(input logic [StepW-1:0] step);
		logic [WordW-1:0] k;
		case (step)
			StepGolden: k = Golden;
			StepSmA:    k = SmMulA;
			StepSmB:    k = SmMulB;
			StepLow:    k = LowMul;
			StepHiA:    k = HiXor;
			StepHiB:    k = HiMulB;
			StepHigh:   k = SmMulB;
			default:    k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
			input int unsigned r);
		return (x << r) | (x >> (WordW - r));
	endfunction

endpackage

// ===== rtl/two_lane_word_fingerprint.sv =====
// two-lane 128-bit fingerprint of a message fed one 64-bit word per request.
// each word is offset by the golden-ratio constant times (index + 1), run
// through a splitmix64 finaliser and folded into a low lane (xor, rotate 23,
// multiply) and a high lane (second mix added in, rotate 37, multiply). the
// request flagged by tlast also emits {high, low} on the master side, with a
// zero lane replaced by a fixed constant, and then reseeds both lanes and the
// index. the word index saturates at 0xffffffff until the message ends.
// datapath: every word costs seven 64-bit multiplications, each done as three
// 32x32 partial products on one shared multiplier, in phases (three products,
// a final sum, an operand update); after the last multiplication a word passes
// a finishing state and returns to idle, where the next request is accepted.
// s_axis_tready is low while a word is being worked on. a finished result
// sits in an output register; the next word is accepted while it waits, and
// only a following last word holds in its finishing state until it is taken.
module two_lane_word_fingerprint (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // [63:0] data_word
	input  logic         s_axis_tlast,  // last_word
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // [63:0] fingerprint_low, [127:64] fingerprint_high
);
	import tlwf_pkg::*;

	state_t              state_q;
	logic [StepW-1:0]    step_q;
	logic [PhaseW-1:0]   phase_q;
	logic [WordW-1:0]    low_q;
	logic [WordW-1:0]    high_q;
	logic [IndexW-1:0]   index_q;
	logic                out_valid_q;
	logic [2*WordW-1:0]  out_q;

	// datapath payload
	logic [WordW-1:0]    data_q;
	logic                last_q;
	logic [WordW-1:0]    a_q;     // multiplicand of the current step
	logic [WordW-1:0]    h_q;     // high-lane operand held across the low-lane step
	logic [WordW-1:0]    prod_q;  // registered 32x32 partial product
	logic [WordW-1:0]    acc_q;
	logic [WordW-1:0]    res_q;   // low 64 bits of the finished product

	logic [WordW-1:0]    k;
	logic [HalfW-1:0]    mul_a;
	logic [HalfW-1:0]    mul_b;
	logic [WordW-1:0]    mul_p;
	logic [WordW-1:0]    prod_sh;
	logic [WordW-1:0]    a_next;
	logic [WordW-1:0]    h_next;
	logic [WordW-1:0]    m0;
	logic [WordW-1:0]    m2;
	logic [WordW-1:0]    mh;
	logic [WordW-1:0]    first_a;
	logic                in_take;
	logic                out_take;
	logic                finish;

	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign out_take = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// a last word may only finish once the output register is free
	assign finish = (state_q == ST_DONE) && (!last_q || !out_valid_q || m_axis_tready);

	// index + 1 needs 33 bits once the index has saturated
	assign first_a = {{(WordW-IndexW-1){1'b0}}, {1'b0, index_q} + {{IndexW{1'b0}}, 1'b1}};

	// shared multiplier: lo*lo, hi*lo, lo*hi; the hi*hi term falls off the top
	assign k     = step_const(step_q);
	assign mul_a = (phase_q == PhHiLo) ? a_q[WordW-1:HalfW] : a_q[HalfW-1:0];
	assign mul_b = (phase_q == PhLoHi) ? k[WordW-1:HalfW] : k[HalfW-1:0];
	assign mul_p = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};
	assign prod_sh = {prod_q[HalfW-1:0], {HalfW{1'b0}}};

	// operand for the next step, from the finished product
	always_comb begin
		m0     = data_q + res_q;
		m2     = res_q ^ (res_q >> 31);
		mh     = m2 ^ HiXor;
		h_next = h_q;
		case (step_q)
			StepGolden: a_next = m0 ^ (m0 >> 30);
			StepSmA:    a_next = res_q ^ (res_q >> 27);
			StepSmB: begin
				a_next = rotl(low_q ^ m2, 23);
				h_next = mh ^ (mh >> 32);
			end
			StepLow:    a_next = h_q;
			StepHiA:    a_next = res_q ^ (res_q >> 32);
			StepHiB:    a_next = rotl(high_q + (res_q ^ (res_q >> 32)), 37);
			default:    a_next = a_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= StepGolden;
			phase_q     <= PhLoLo;
			low_q       <= SeedLow;
			high_q      <= SeedHigh;
			index_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces one taken in the same cycle
			if (finish && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_RUN;
						step_q  <= StepGolden;
						phase_q <= PhLoLo;
					end
				end
				ST_RUN: begin
					if (phase_q == PhPost) begin
						phase_q <= PhLoLo;
						if (step_q == StepLow) begin
							low_q <= res_q;
						end
						if (step_q == StepHigh) begin
							high_q  <= res_q;
							state_q <= ST_DONE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							low_q       <= SeedLow;
							high_q      <= SeedHigh;
							index_q     <= '0;
						end else if (index_q != {IndexW{1'b1}}) begin
							index_q <= index_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (in_take) begin
			data_q <= s_axis_tdata;
			last_q <= s_axis_tlast;
			a_q    <= first_a;
		end
		if (state_q == ST_RUN) begin
			case (phase_q)
				PhHiLo:  acc_q <= prod_q;
				PhLoHi:  acc_q <= acc_q + prod_sh;
				PhSum:   res_q <= acc_q + prod_sh;
				PhPost: begin
					a_q <= a_next;
					h_q <= h_next;
				end
				default: ;
			endcase
		end
		if (finish && last_q) begin
			out_q[WordW-1:0]       <= (low_q == '0) ? LowFill : low_q;
			out_q[2*WordW-1:WordW] <= (high_q == '0) ? HighFill : high_q;
		end
	end

	// phase counter never runs past the operand update
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PhPost)
		else $error("phase counter out of range");

	// an accepted word always starts the multiply sequence at its first step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_RUN && step_q == StepGolden && phase_q == PhLoLo))
		else $error("word did not start at first step");

	// a result appears only from the finishing cycle of a last word
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE && last_q))
		else $error("result raised outside a last word");

	// after a result is loaded the lanes are back at their seeds
	a_reseed: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && last_q) |=> (low_q == SeedLow && high_q == SeedHigh && index_q == '0))
		else $error("lanes not reseeded after result");

endmodule

// ===== verif/two_lane_word_fingerprint_tb.sv =====
`default_nettype none

module two_lane_word_fingerprint_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlwf_pkg::*;

	// run length guard, far above the slowest legal run (about 1600 requests,
	// plus sender gaps, receiver stalls and the long hold-off)
	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned HoldCycles = 600;
	localparam int unsigned TailCycles = 100;
	localparam int unsigned RandWords  = 1580;

	typedef struct {
		logic [WordW-1:0] word;
		logic             last;
	} word_req_t;

	typedef struct {
		logic [WordW-1:0] low;
		logic [WordW-1:0] high;
	} fingerprint_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata = '0;   // [63:0] data_word
	logic          s_axis_tlast = 1'b0; // last_word
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [127:0]  m_axis_tdata;        // [63:0] fingerprint_low, [127:64] fingerprint_high

	// requests waiting to be offered, and fingerprints still owed by the block
	word_req_t     word_queue[$];
	fingerprint_t  fp_expect[$];

	// predicted fingerprint state, mirrors the block after each accepted word
	logic [WordW-1:0]  lane_low  = SeedLow;
	logic [WordW-1:0]  lane_high = SeedHigh;
	logic [IndexW-1:0] word_pos  = '0;

	logic        in_taken = 1'b0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned hold_arm = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	two_lane_word_fingerprint u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// fold one accepted word into the predicted lanes; a last word also yields
	// the fingerprint (zero lanes swapped for their fill values) and reseeds
	task automatic absorb_word(input logic [WordW-1:0] word, input logic last);
		logic [WordW-1:0] mix;
		logic [WordW-1:0] step;
		fingerprint_t     fp;
		step = {32'h0, word_pos} + 64'd1;
		mix  = word + Golden * step;
		mix  = (mix ^ (mix >> 30)) * SmMulA;
		mix  = (mix ^ (mix >> 27)) * SmMulB;
		mix  = mix ^ (mix >> 31);

		lane_low = lane_low ^ mix;
		lane_low = {lane_low[40:0], lane_low[63:41]} * LowMul;   // rotate left by 23

		// second derived mix for the high lane
		mix = mix ^ HiXor;
		mix = (mix ^ (mix >> 32)) * HiXor;
		mix = (mix ^ (mix >> 32)) * HiMulB;
		mix = mix ^ (mix >> 32);
		lane_high = lane_high + mix;
		lane_high = {lane_high[26:0], lane_high[63:27]} * SmMulB; // rotate left by 37

		// index saturates rather than wrapping on very long messages
		if (word_pos != '1) begin
			word_pos = word_pos + 1'b1;
		end

		if (last) begin
			fp.low  = (lane_low == '0) ? LowFill : lane_low;
			fp.high = (lane_high == '0) ? HighFill : lane_high;
			fp_expect = {fp_expect, fp};
			lane_low  = SeedLow;
			lane_high = SeedHigh;
			word_pos  = '0;
		end
	endtask

	// monitor: sample both handshakes at the rising edge, predict on input
	// requests and compare fingerprints field by field on output requests
	always @(posedge clk) begin : watch_ports
		fingerprint_t fp;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			absorb_word(s_axis_tdata, s_axis_tlast);
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (fp_expect.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected fingerprint: expected none, got %h", $time,
					m_axis_tdata);
			end else begin
				fp = fp_expect.pop_front();
				if (m_axis_tdata[63:0] !== fp.low) begin
					mismatches++;
					$display("%0t: fingerprint_low: expected %h, got %h", $time, fp.low,
						m_axis_tdata[63:0]);
				end
				if (m_axis_tdata[127:64] !== fp.high) begin
					mismatches++;
					$display("%0t: fingerprint_high: expected %h, got %h", $time, fp.high,
						m_axis_tdata[127:64]);
				end
			end
		end
	end

	// driver: a new request goes out at the falling edge once the previous one
	// has been taken, unless the sender chooses to idle this cycle
	always @(negedge clk) begin : drive_words
		word_req_t req;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_taken) begin
			if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				req = word_queue.pop_front();
				s_axis_tdata  <= req.word;
				s_axis_tlast  <= req.last;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, plus a long hold-off counted here so the
	// output register fills and a following last word stalls the input side
	always @(negedge clk) begin : drive_ready
		int unsigned hold_seen;
		int unsigned hold_left;
		if (hold_arm != hold_seen) begin
			hold_seen = hold_arm;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin : guard
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// biased word values: extremes and single-bit patterns show up often
	function automatic logic [WordW-1:0] pick_word();
		logic [WordW-1:0] one_hot;
		one_hot = 64'd1 << $urandom_range(0, 63);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return one_hot;
			3:       return ~one_hot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_word(input logic [WordW-1:0] word, input logic last);
		word_req_t req;
		req.word = word;
		req.last = last;
		word_queue = {word_queue, req};
	endtask

	// one message of random length: mostly short, now and then a long one
	task automatic queue_message(output int unsigned len);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
		for (int unsigned i = 0; i < len; i++) begin
			queue_word(pick_word(), i == len - 1);
		end
	endtask

	task automatic queue_random(input int unsigned words);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < words) begin
			queue_message(len);
			sent += len;
		end
	endtask

	// wait until every request has gone out and every fingerprint has come back
	task automatic drain();
		while (word_queue.size() != 0 || s_axis_tvalid || fp_expect.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// sender idles a little, receiver a lot
		send_idle = 19;
		recv_idle = 77;

		// single-word messages at the data extremes
		queue_word('0, 1'b1);
		queue_word('1, 1'b1);
		queue_word(64'd1, 1'b1);
		queue_word(64'h8000_0000_0000_0000, 1'b1);
		// short messages with alternating patterns
		queue_word('0, 1'b0);
		queue_word('1, 1'b0);
		queue_word(64'h5555_5555_5555_5555, 1'b0);
		queue_word(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		queue_word(64'h0123_4567_89ab_cdef, 1'b0);
		queue_word(64'hfedc_ba98_7654_3210, 1'b1);
		// longer message so the index climbs and the same word differs by position
		for (int unsigned i = 0; i < 8; i++) begin
			queue_word(64'hdead_beef_0000_0000, i == 7);
		end
		drain();

		// long receiver hold-off while a burst of single-word messages is offered
		hold_arm++;
		for (int unsigned i = 0; i < 8; i++) begin
			queue_word(pick_word(), 1'b1);
		end
		queue_random(RandWords / 3);
		drain();

		// sender idles a lot, receiver a little; pause midway until all is back
		send_idle = 77;
		recv_idle = 19;
		queue_random(RandWords / 6);
		drain();
		queue_random(RandWords / 6);
		drain();

		// full throughput on both sides
		send_idle = 0;
		recv_idle = 0;
		queue_random(RandWords / 3);
		drain();

		// let the block settle so a stray late fingerprint would still be caught
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0 && fp_expect.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tlwf_pkg.sv
rtl/two_lane_word_fingerprint.sv
verif/two_lane_word_fingerprint_tb.sv
